>>> src/chs_pkg.sv
// Shared constants and types for the cosine-weighted hemisphere sampler.
// No dependencies; other files refer to it by scoped names.
package chs_pkg;

	// Q2.30 unity and fixed-point constants
	localparam logic [30:0] Q30_ONE    = 31'd1073741824;
	localparam logic [31:0] PI_Q30     = 32'd3373259426;
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

	// reciprocals for exact floor division of values below 2^30
	localparam logic [30:0] DIV42_M = 31'd1636178018; // >> 36
	localparam logic [30:0] DIV56_M = 31'd1227133514; // >> 36
	localparam logic [30:0] DIV20_M = 31'd1717986919; // >> 35
	localparam logic [30:0] DIV30_M = 31'd1145324613; // >> 35
	localparam logic [30:0] DIV6_M  = 31'd1431655766; // >> 33
	localparam logic [30:0] DIV12_M = 31'd1431655766; // >> 34

	// one rotation matrix entry, Q30, held within +-2^31
	typedef logic signed [32:0] entry_t;
	// row-major 3x3 matrix, element 3*row+col
	typedef entry_t [8:0] mat_t;

	// rotated unit circle point, Q30
	typedef struct packed {
		logic signed [31:0] ca;
		logic signed [31:0] sa;
	} trig_pair_t;

endpackage

>>> src/chs_sample_if.sv
// Input channel of the sampler: two uniforms and a surface normal.
// Valid/ready handshake; no dependencies.
interface chs_sample_if;
	logic               valid;
	logic               ready;
	logic [15:0]        uniform_radius;
	logic [15:0]        uniform_angle;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;

	modport source (output valid, uniform_radius, uniform_angle, normal_x, normal_y,
		normal_z, input ready);
	modport sink (input valid, uniform_radius, uniform_angle, normal_x, normal_y,
		normal_z, output ready);
endinterface

>>> src/chs_ray_if.sv
// Output channel of the sampler: world direction and density.
// Valid/ready handshake; no dependencies.
interface chs_ray_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic [14:0]        density;

	modport source (output valid, dir_x, dir_y, dir_z, density, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, density, output ready);
endinterface

>>> src/chs_sqrt.sv
// Pipelined integer square root, floor(sqrt(radicand)), three result bits per stage.
// Standalone; registers advance only while en is high.
module chs_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [35:0] radicand,
	output logic [16:0] root
);
	localparam int STAGES = 6;
	localparam int PER = 3;

	typedef struct packed {
		logic [19:0] rem;
		logic [17:0] res;
	} sq_acc_t;

	sq_acc_t     acc_s [STAGES];
	logic [35:0] rad_s [STAGES-1];
	sq_acc_t     nxt   [STAGES];

	// one digit-by-digit step on the next pair of radicand bits
	function automatic sq_acc_t sq_iter(sq_acc_t a, logic [1:0] pair);
		logic [21:0] sh;
		logic [21:0] trial;
		sq_acc_t     o;
		sh    = {a.rem, pair};
		trial = {2'b00, a.res, 2'b01};
		if (sh >= trial) begin
			o.rem = 20'(sh - trial);
			o.res = {a.res[16:0], 1'b1};
		end else begin
			o.rem = sh[19:0];
			o.res = {a.res[16:0], 1'b0};
		end
		return o;
	endfunction

	function automatic sq_acc_t sq_stage(sq_acc_t a, logic [35:0] rad, int stg);
		sq_acc_t o;
		o = a;
		for (int j = 0; j < PER; j++) begin
			o = sq_iter(o, rad[35 - 2 * (PER * stg + j) -: 2]);
		end
		return o;
	endfunction

	always_comb begin
		nxt[0] = sq_stage('0, radicand, 0);
		for (int k = 1; k < STAGES; k++) begin
			nxt[k] = sq_stage(acc_s[k-1], (k == 1) ? rad_s[0] : rad_s[k-1], k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= nxt[0];
			rad_s[0] <= radicand;
			for (int k = 1; k < STAGES; k++) begin
				acc_s[k] <= nxt[k];
			end
			for (int k = 1; k < STAGES - 1; k++) begin
				rad_s[k] <= rad_s[k-1];
			end
		end
	end

	assign root = acc_s[STAGES-1].res[16:0];

endmodule

>>> src/chs_trig.sv
// Sine/cosine of 2*pi*u2 by Taylor polynomials in Q2.30, one multiply per stage and path.
// Uses chs_pkg constants; registers advance only while en is high.
module chs_trig (
	input  logic                clk,
	input  logic                en,
	input  logic [15:0]         uniform_angle,
	output chs_pkg::trig_pair_t trig
);
	logic [15:0] ang;
	logic [13:0] at;
	logic [45:0] prod_a1;
	logic [59:0] prod_a2;
	logic [60:0] p42, p56, ms4, mc4, p20, p30, ms6, mc6, p6, p12, sv8, mc8;

	logic [29:0] x_s  [1:7];
	logic [29:0] x2_s [2:7];
	logic [1:0]  q_s  [1:8];
	logic        neg_s [1:8];
	logic [30:0] s3_s3, c4_s3, s2_s5, c3_s5, s1_s7, c2_s7;
	logic [29:0] ms_s4, mc_s4, ms_s6, mc_s6, sv_s8, mc_s8;

	logic [30:0]        cv;
	logic signed [31:0] svs, cvs;
	chs_pkg::trig_pair_t rot;

	// reduce the angle to an octant around a quadrant center
	always_comb begin
		ang = uniform_angle + 16'd8192;
		at  = ang[13] ? {1'b0, ang[12:0]} : 14'(14'd8192 - {1'b0, ang[12:0]});
		prod_a1 = 46'(at) * 46'(chs_pkg::PI_Q30);
		prod_a2 = 60'(x_s[1]) * 60'(x_s[1]);
	end

	// polynomial products, one per stage and path
	always_comb begin
		p42 = 61'(x2_s[2]) * 61'(chs_pkg::DIV42_M);
		p56 = 61'(x2_s[2]) * 61'(chs_pkg::DIV56_M);
		ms4 = 61'(x2_s[3]) * 61'(s3_s3);
		mc4 = 61'(x2_s[3]) * 61'(c4_s3);
		p20 = 61'(ms_s4) * 61'(chs_pkg::DIV20_M);
		p30 = 61'(mc_s4) * 61'(chs_pkg::DIV30_M);
		ms6 = 61'(x2_s[5]) * 61'(s2_s5);
		mc6 = 61'(x2_s[5]) * 61'(c3_s5);
		p6  = 61'(ms_s6) * 61'(chs_pkg::DIV6_M);
		p12 = 61'(mc_s6) * 61'(chs_pkg::DIV12_M);
		sv8 = 61'(x_s[7]) * 61'(s1_s7);
		mc8 = 61'(x2_s[7]) * 61'(c2_s7);
	end

	// final cosine term, sign of sine, quadrant rotation
	always_comb begin
		cv  = chs_pkg::Q30_ONE - {2'b00, mc_s8[29:1]};
		svs = neg_s[8] ? -$signed({2'b00, sv_s8}) : $signed({2'b00, sv_s8});
		cvs = $signed({1'b0, cv});
		unique case (q_s[8])
			2'd0: begin
				rot.ca = cvs;
				rot.sa = svs;
			end
			2'd1: begin
				rot.ca = -svs;
				rot.sa = cvs;
			end
			2'd2: begin
				rot.ca = -cvs;
				rot.sa = -svs;
			end
			default: begin
				rot.ca = svs;
				rot.sa = -cvs;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[1]   <= prod_a1[44:15];
			q_s[1]   <= ang[15:14];
			neg_s[1] <= !ang[13];
			for (int k = 2; k <= 7; k++) begin
				x_s[k] <= x_s[k-1];
			end
			for (int k = 2; k <= 8; k++) begin
				q_s[k]   <= q_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
			x2_s[2] <= prod_a2[59:30];
			for (int k = 3; k <= 7; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			s3_s3 <= chs_pkg::Q30_ONE - 31'(p42 >> 36);
			c4_s3 <= chs_pkg::Q30_ONE - 31'(p56 >> 36);
			ms_s4 <= ms4[59:30];
			mc_s4 <= mc4[59:30];
			s2_s5 <= chs_pkg::Q30_ONE - 31'(p20 >> 35);
			c3_s5 <= chs_pkg::Q30_ONE - 31'(p30 >> 35);
			ms_s6 <= ms6[59:30];
			mc_s6 <= mc6[59:30];
			s1_s7 <= chs_pkg::Q30_ONE - 31'(p6 >> 33);
			c2_s7 <= chs_pkg::Q30_ONE - 31'(p12 >> 34);
			sv_s8 <= sv8[59:30];
			mc_s8 <= mc8[59:30];
			trig  <= rot;
		end
	end

endmodule

>>> src/chs_div.sv
// Pipelined restoring divider: (num * 2^16) / den, quotient saturated at 2^32.
// Standalone; four quotient bits per stage, registers advance only while en is high.
module chs_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic [32:0] quo
);
	localparam int PER = 4;
	localparam int STAGES = 32 / PER;

	// remainder and a word that shifts dividend bits out and quotient bits in
	typedef struct packed {
		logic [15:0] rem;
		logic [31:0] wk;
	} div_acc_t;

	div_acc_t    acc_s [STAGES];
	logic [15:0] den_s [STAGES-1];
	logic        sat_s [STAGES];
	div_acc_t    nxt   [STAGES];

	function automatic div_acc_t div_stage(div_acc_t a, logic [15:0] d);
		logic [16:0] sh;
		div_acc_t    o;
		o = a;
		for (int j = 0; j < PER; j++) begin
			sh   = {o.rem, o.wk[31]};
			o.wk = {o.wk[30:0], 1'b0};
			if (sh >= {1'b0, d}) begin
				o.rem   = 16'(sh - {1'b0, d});
				o.wk[0] = 1'b1;
			end else begin
				o.rem = sh[15:0];
			end
		end
		return o;
	endfunction

	always_comb begin
		nxt[0] = div_stage({num[31:16], num[15:0], 16'h0000}, den);
		for (int k = 1; k < STAGES; k++) begin
			nxt[k] = div_stage(acc_s[k-1], den_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= nxt[0];
			den_s[0] <= den;
			// high part already at or above the divisor: quotient >= 2^32
			sat_s[0] <= (num[31:16] >= den);
			for (int k = 1; k < STAGES; k++) begin
				acc_s[k] <= nxt[k];
				sat_s[k] <= sat_s[k-1];
			end
			for (int k = 1; k < STAGES - 1; k++) begin
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign quo = sat_s[STAGES-1] ? 33'h1_0000_0000 : {1'b0, acc_s[STAGES-1].wk};

endmodule

>>> src/chs_matrix.sv
// Rotation matrix taking +z onto the normal (Rodrigues form), half turn about x
// when the normal points down. Uses chs_pkg and chs_div.
module chs_matrix (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output chs_pkg::mat_t      mat
);
	logic signed [31:0] sqx, sqy, pxy;
	logic signed [16:0] dsum;

	logic [30:0]        sqx_s1, sqy_s1;
	logic signed [31:0] pxy_s1;
	logic [15:0]        den_s1, den_s2;
	logic signed [15:0] nx_s [1:10];
	logic signed [15:0] ny_s [1:10];
	logic               spec_s [1:10];
	logic               sxy_s [2:10];
	logic [31:0]        nxx_s2, nyy_s2, nrr_s2, nxy_s2;
	logic [32:0]        qxx, qyy, qrr, qxy;

	chs_pkg::mat_t      mnext;
	chs_pkg::entry_t    mxy, mnx, mny;
	logic signed [34:0] qxy_w;

	function automatic chs_pkg::entry_t clamp_entry(logic signed [34:0] v);
		chs_pkg::entry_t o;
		if (v > 35'sd2147483648) begin
			o = 33'sd2147483648;
		end else if (v < -35'sd2147483648) begin
			o = -33'sd2147483648;
		end else begin
			o = v[32:0];
		end
		return o;
	endfunction

	// squares and cross term of the normal
	always_comb begin
		sqx  = normal_x * normal_x;
		sqy  = normal_y * normal_y;
		pxy  = normal_x * normal_y;
		dsum = {normal_z[15], normal_z} + 17'sd16384;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1    <= sqx[30:0];
			sqy_s1    <= sqy[30:0];
			pxy_s1    <= pxy;
			den_s1    <= dsum[15:0];
			nx_s[1]   <= normal_x;
			ny_s[1]   <= normal_y;
			spec_s[1] <= (normal_z <= -16'sd16383);
			for (int k = 2; k <= 10; k++) begin
				nx_s[k]   <= nx_s[k-1];
				ny_s[k]   <= ny_s[k-1];
				spec_s[k] <= spec_s[k-1];
			end
			// dividends: magnitudes, sign of the cross term kept aside
			nxx_s2   <= {1'b0, sqx_s1};
			nyy_s2   <= {1'b0, sqy_s1};
			nrr_s2   <= 32'(sqx_s1) + 32'(sqy_s1);
			nxy_s2   <= pxy_s1[31] ? 32'(-pxy_s1) : 32'(pxy_s1);
			sxy_s[2] <= pxy_s1[31];
			den_s2   <= den_s1;
			for (int k = 3; k <= 10; k++) begin
				sxy_s[k] <= sxy_s[k-1];
			end
			mat <= mnext;
		end
	end

	chs_div u_div_xx (.clk(clk), .en(en), .num(nxx_s2), .den(den_s2), .quo(qxx));
	chs_div u_div_yy (.clk(clk), .en(en), .num(nyy_s2), .den(den_s2), .quo(qyy));
	chs_div u_div_rr (.clk(clk), .en(en), .num(nrr_s2), .den(den_s2), .quo(qrr));
	chs_div u_div_xy (.clk(clk), .en(en), .num(nxy_s2), .den(den_s2), .quo(qxy));

	// matrix entries from the quotients
	always_comb begin
		qxy_w = $signed({2'b00, qxy});
		mxy   = clamp_entry(sxy_s[10] ? qxy_w : -qxy_w);
		mnx   = {nx_s[10][15], nx_s[10], 16'h0000};
		mny   = {ny_s[10][15], ny_s[10], 16'h0000};
		if (spec_s[10]) begin
			mnext    = '0;
			mnext[0] = 33'sd1073741824;
			mnext[4] = -33'sd1073741824;
			mnext[8] = -33'sd1073741824;
		end else begin
			mnext[0] = clamp_entry($signed({4'b0000, chs_pkg::Q30_ONE}) - $signed({2'b00, qxx}));
			mnext[1] = mxy;
			mnext[2] = mnx;
			mnext[3] = mxy;
			mnext[4] = clamp_entry($signed({4'b0000, chs_pkg::Q30_ONE}) - $signed({2'b00, qyy}));
			mnext[5] = mny;
			mnext[6] = -mnx;
			mnext[7] = -mny;
			mnext[8] = clamp_entry($signed({4'b0000, chs_pkg::Q30_ONE}) - $signed({2'b00, qrr}));
		end
	end

endmodule

>>> src/cosine_hemisphere_sampler.sv
// Top level of the cosine-weighted hemisphere sampler.
// Uses chs_pkg, chs_sample_if, chs_ray_if, chs_sqrt, chs_trig, chs_matrix.
//
// Streaming sampler: one item enters per clock while the pipeline advances,
// and its direction and density leave at the end of the pipeline. Square
// roots (6 stages) and sine/cosine polynomials (9 stages) run beside the
// rotation matrix build (two product stages, an 8-stage divider, an entry
// stage), followed by scaling of the local direction, the matrix-vector
// products, the sums and the final round and saturate. When the output item
// is not taken the whole pipeline holds and input ready drops.
module cosine_hemisphere_sampler (
	input  logic       clk,
	input  logic       arst_n,
	chs_sample_if.sink sample,
	chs_ray_if.source  ray
);
	localparam int DEPTH = 14;

	logic              adv;
	logic [DEPTH:1]    valid_s;
	logic [35:0]       rad_r, rad_c;
	logic [16:0]       r_root, cz_root;
	chs_pkg::trig_pair_t trig;
	chs_pkg::mat_t     mat;

	logic [15:0]        r_s [7:9];
	logic [16:0]        cz_s [7:11];
	logic signed [48:0] lxp, lyp;
	logic [47:0]        dprod;
	logic signed [31:0] lx_s10, ly_s10, lx_s11, ly_s11;
	logic [14:0]        dens_s [10:14];
	logic signed [63:0] pr_s12 [9];
	logic signed [63:0] acc_s13 [3];
	logic signed [63:0] sh [3];
	logic signed [15:0] dir_s14 [3];
	logic signed [15:0] sat [3];

	// global advance: the pipeline moves unless a finished item is held
	assign adv          = !valid_s[DEPTH] || ray.ready;
	assign sample.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[DEPTH-1:1], sample.valid};
		end
	end

	// radicands u1*2^16 and (1-u1)*2^16
	assign rad_r = {4'h0, sample.uniform_radius, 16'h0000};
	assign rad_c = {3'b000, 17'(17'h10000 - {1'b0, sample.uniform_radius}), 16'h0000};

	chs_sqrt u_sqrt_r (.clk(clk), .en(adv), .radicand(rad_r), .root(r_root));
	chs_sqrt u_sqrt_c (.clk(clk), .en(adv), .radicand(rad_c), .root(cz_root));

	chs_trig u_trig (.clk(clk), .en(adv), .uniform_angle(sample.uniform_angle), .trig(trig));

	chs_matrix u_matrix (
		.clk(clk),
		.en(adv),
		.normal_x(sample.normal_x),
		.normal_y(sample.normal_y),
		.normal_z(sample.normal_z),
		.mat(mat)
	);

	// local direction and density
	always_comb begin
		lxp   = 49'($signed({1'b0, r_s[9]})) * 49'(trig.ca);
		lyp   = 49'($signed({1'b0, r_s[9]})) * 49'(trig.sa);
		dprod = 48'(cz_s[9]) * 48'(chs_pkg::INV_PI_Q32) + 48'h0000_8000_0000;
	end

	// round half up, then saturate to the unit range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = acc_s13[i] >>> 46;
			if (sh[i] > 64'sd16384) begin
				sat[i] = 16'sd16384;
			end else if (sh[i] < -64'sd16384) begin
				sat[i] = -16'sd16384;
			end else begin
				sat[i] = sh[i][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s[7]  <= r_root[15:0];
			cz_s[7] <= cz_root;
			for (int k = 8; k <= 9; k++) begin
				r_s[k] <= r_s[k-1];
			end
			for (int k = 8; k <= 11; k++) begin
				cz_s[k] <= cz_s[k-1];
			end
			lx_s10     <= lxp[47:16];
			ly_s10     <= lyp[47:16];
			dens_s[10] <= dprod[46:32];
			lx_s11     <= lx_s10;
			ly_s11     <= ly_s10;
			for (int k = 11; k <= 14; k++) begin
				dens_s[k] <= dens_s[k-1];
			end
			// matrix times local direction, lz = cz * 2^14
			for (int i = 0; i < 3; i++) begin
				pr_s12[3*i]   <= 64'($signed(mat[3*i])) * 64'(lx_s11);
				pr_s12[3*i+1] <= 64'($signed(mat[3*i+1])) * 64'(ly_s11);
				pr_s12[3*i+2] <= (64'($signed(mat[3*i+2])) *
					64'($signed({1'b0, cz_s[11]}))) <<< 14;
			end
			for (int i = 0; i < 3; i++) begin
				acc_s13[i] <= pr_s12[3*i] + pr_s12[3*i+1] + pr_s12[3*i+2] +
					64'sd35184372088832;
				dir_s14[i] <= sat[i];
			end
		end
	end

	assign ray.valid   = valid_s[DEPTH];
	assign ray.dir_x   = dir_s14[0];
	assign ray.dir_y   = dir_s14[1];
	assign ray.dir_z   = dir_s14[2];
	assign ray.density = dens_s[14];

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && !ray.ready |-> !sample.ready)
		else $error("input taken while the output item is held");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> valid_s[1])
		else $error("accepted item lost at pipeline entry");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid |-> (ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384 &&
		ray.dir_y <= 16'sd16384 && ray.dir_y >= -16'sd16384 &&
		ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384))
		else $error("direction component outside saturation range");

	a_density_max: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid |-> ray.density <= 15'd20861)
		else $error("density above 1/pi");

endmodule

>>> test/tb_chs_ifs.sv
// Testbench-side latency constant of the sampler.
// No dependencies; holds no logic of its own.
package tb_chs_pkg;
	localparam int LATENCY = 14;
endpackage

>>> test/tb_top.sv
// Stream test of the cosine-weighted hemisphere sampler: directed samples, then
// random ones, each checked against a typed-in result or a bit-exact predictor.
// Depends on tb_chs_pkg, chs_pkg, chs_sample_if, chs_ray_if, cosine_hemisphere_sampler.
module tb_top;
	localparam longint ONE_Q30   = 64'd1073741824;
	localparam longint PI_Q30_C  = 64'd3373259426;
	localparam longint INVPI_Q32 = 64'd1367130551;
	localparam longint ENTRY_MAX = 64'd2147483648;
	localparam int     N_RANDOM  = 750;
	localparam longint CYCLE_CAP = 400000;

	typedef struct packed {
		logic [15:0]        radius;
		logic [15:0]        angle;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic [14:0]        dens;
	} ray_t;

	// directed row: sample, typed-in result, and whether that result is used
	typedef struct {
		sample_t s;
		ray_t    r;
		bit      typed;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	chs_sample_if sample_ch();
	chs_ray_if    ray_ch();

	cosine_hemisphere_sampler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.ray    (ray_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ray_t   pending_rays[$];
	int     errors = 0;
	longint cycles = 0;
	bit     sending_done = 1'b0;
	int     hold_off = 0;

	// floor division by 2^s for signed values
	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v = v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic longint mul30(longint a, longint b);
		return (a * b) >> 30;
	endfunction

	function automatic longint clip_entry(longint v);
		if (v > ENTRY_MAX) return ENTRY_MAX;
		if (v < -ENTRY_MAX) return -ENTRY_MAX;
		return v;
	endfunction

	function automatic logic signed [15:0] round_dir(longint acc);
		longint v;
		v = floor_sh(acc + (64'd1 <<< 45), 46);
		if (v > 16384) v = 16384;
		if (v < -16384) v = -16384;
		return v[15:0];
	endfunction

	// bit-exact direction and density for one sample
	function automatic ray_t bounce_ray(sample_t s);
		longint u1, u2, nx, ny, nz, r, cz, a, t, at, x, x2;
		longint s1, s2, s3, c2, c3, c4, sv, cv, ca, sa, d;
		longint xx, yy, xy, rr, acc;
		longint l[3];
		longint m[3][3];
		int q;
		logic signed [15:0] o[3];
		ray_t res;
		u1 = s.radius;
		u2 = s.angle;
		nx = s.nx;
		ny = s.ny;
		nz = s.nz;
		r = int_sqrt(u1 << 16);
		cz = int_sqrt((65536 - u1) << 16);
		a = (u2 + 8192) & 16'hFFFF;
		q = int'(a >> 14);
		t = (a & 16'h3FFF) - 8192;
		at = (t < 0) ? -t : t;
		x = (at * PI_Q30_C) >> 15;
		x2 = mul30(x, x);
		s3 = ONE_Q30 - x2 / 42;
		s2 = ONE_Q30 - mul30(x2, s3) / 20;
		s1 = ONE_Q30 - mul30(x2, s2) / 6;
		sv = mul30(x, s1);
		c4 = ONE_Q30 - x2 / 56;
		c3 = ONE_Q30 - mul30(x2, c4) / 30;
		c2 = ONE_Q30 - mul30(x2, c3) / 12;
		cv = ONE_Q30 - mul30(x2, c2) / 2;
		if (t < 0) sv = -sv;
		case (q)
			0: begin ca = cv; sa = sv; end
			1: begin ca = -sv; sa = cv; end
			2: begin ca = -cv; sa = -sv; end
			default: begin ca = sv; sa = -cv; end
		endcase
		l[0] = floor_sh(r * ca, 16);
		l[1] = floor_sh(r * sa, 16);
		l[2] = cz * 16384;
		if (nz <= -16383) begin
			// normal facing -z: half turn about x
			foreach (m[i, j]) m[i][j] = 0;
			m[0][0] = ONE_Q30;
			m[1][1] = -ONE_Q30;
			m[2][2] = -ONE_Q30;
		end else begin
			d = 16384 + nz;
			xx = (nx * nx * 65536) / d;
			yy = (ny * ny * 65536) / d;
			xy = (nx * ny * 65536) / d;
			rr = ((nx * nx + ny * ny) * 65536) / d;
			m[0][0] = clip_entry(ONE_Q30 - xx);
			m[0][1] = clip_entry(-xy);
			m[0][2] = clip_entry(nx * 65536);
			m[1][0] = clip_entry(-xy);
			m[1][1] = clip_entry(ONE_Q30 - yy);
			m[1][2] = clip_entry(ny * 65536);
			m[2][0] = clip_entry(-nx * 65536);
			m[2][1] = clip_entry(-ny * 65536);
			m[2][2] = clip_entry(ONE_Q30 - rr);
		end
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * l[0] + m[i][1] * l[1] + m[i][2] * l[2];
			o[i] = round_dir(acc);
		end
		res.dx = o[0];
		res.dy = o[1];
		res.dz = o[2];
		res.dens = 15'((cz * INVPI_Q32 + (64'd1 << 31)) >> 32);
		return res;
	endfunction

	function automatic sample_t mk(int u1, int u2, int x, int y, int z);
		sample_t s;
		s.radius = u1[15:0];
		s.angle = u2[15:0];
		s.nx = x[15:0];
		s.ny = y[15:0];
		s.nz = z[15:0];
		return s;
	endfunction

	function automatic ray_t mkr(int x, int y, int z, int p);
		ray_t r;
		r.dx = x[15:0];
		r.dy = y[15:0];
		r.dz = z[15:0];
		r.dens = p[14:0];
		return r;
	endfunction

	// random normal: mostly unit-ish, sometimes arbitrary bits
	function automatic sample_t rand_sample();
		sample_t s;
		int k;
		s.radius = 16'($urandom);
		s.angle = 16'($urandom);
		k = $urandom_range(0, 9);
		if (k < 6) begin
			s.nx = 16'($urandom_range(0, 32768) - 16384);
			s.ny = 16'($urandom_range(0, 32768) - 16384);
			s.nz = 16'($urandom_range(0, 32768) - 16384);
		end else if (k < 8) begin
			s.nx = 16'($urandom_range(0, 200) - 100);
			s.ny = 16'($urandom_range(0, 200) - 100);
			s.nz = (k == 6) ? 16'sd16384 : 16'(-16384 + $urandom_range(0, 3));
		end else begin
			s.nx = 16'($urandom);
			s.ny = 16'($urandom);
			s.nz = 16'($urandom);
		end
		if ($urandom_range(0, 15) == 0) s.radius = $urandom_range(0, 1) ? 16'h0 : 16'hFFFF;
		return s;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// hands one sample over, expectation queued at acceptance
	task automatic send_sample(sample_t s, ray_t want);
		int g;
		g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		// idle gap: valid low so the previous item is not offered again
		if (g > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.uniform_radius <= s.radius;
		sample_ch.uniform_angle <= s.angle;
		sample_ch.normal_x <= s.nx;
		sample_ch.normal_y <= s.ny;
		sample_ch.normal_z <= s.nz;
		do @(posedge clk); while (!sample_ch.ready);
		pending_rays.push_back(want);
	endtask

	row_t rows[$];

	// stimulus
	initial begin
		sample_t s;
		sample_ch.valid = 1'b0;
		sample_ch.uniform_radius = '0;
		sample_ch.uniform_angle = '0;
		sample_ch.normal_x = '0;
		sample_ch.normal_y = '0;
		sample_ch.normal_z = '0;
		// radius zero returns the normal, density at its peak
		rows.push_back('{mk(0, 0, 0, 0, 16384), mkr(0, 0, 16384, 20861), 1});
		rows.push_back('{mk(0, 12345, 16384, 0, 0), mkr(16384, 0, 0, 20861), 1});
		rows.push_back('{mk(0, 0, 0, -16384, 0), mkr(0, -16384, 0, 20861), 1});
		// normal straight down: flipped frame
		rows.push_back('{mk(0, 0, 0, 0, -16384), mkr(0, 0, -16384, 20861), 1});
		rows.push_back('{mk(0, 0, 0, 0, -16383), mkr(0, 0, -16384, 20861), 1});
		rows.push_back('{mk(32768, 16384, 0, 0, -16384), '0, 0});
		rows.push_back('{mk(65535, 0, 0, 0, 16384), '0, 0});
		rows.push_back('{mk(65535, 65535, 0, 0, 16384), '0, 0});
		// quadrant boundaries of the angle
		for (int i = 0; i < 8; i++)
			rows.push_back('{mk(40000, i * 8192, 0, 0, 16384), '0, 0});
		rows.push_back('{mk(20000, 5000, 11585, 0, 11585), '0, 0});
		rows.push_back('{mk(20000, 5000, -9459, 9459, -9459), '0, 0});
		rows.push_back('{mk(50000, 30000, 0, 0, -16382), '0, 0});
		// non-unit normals, clamp and saturation
		rows.push_back('{mk(65535, 9000, 32767, -32768, -16382), '0, 0});
		rows.push_back('{mk(65535, 41000, -32768, 32767, 32767), '0, 0});
		rows.push_back('{mk(1, 1, 16384, 16384, 0), '0, 0});
		rows.push_back('{mk(65535, 65535, -1, -1, -1), '0, 0});
		@(posedge clk);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_sample(rows[i].s, rows[i].typed ? rows[i].r : bounce_ray(rows[i].s));
		for (int i = 0; i < N_RANDOM; i++) begin
			s = rand_sample();
			send_sample(s, bounce_ray(s));
		end
		sample_ch.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver readiness, with one long hold-off mid-run
	initial begin
		int g;
		int n;
		ray_ch.ready = 1'b0;
		wait (arst_n);
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n == 300) begin
				ray_ch.ready <= 1'b0;
				for (hold_off = 0; hold_off < 60; hold_off++) @(posedge clk);
			end
			if (n > 2000 || $urandom_range(0, 3) != 0) begin
				ray_ch.ready <= 1'b1;
			end else begin
				g = gap_len();
				if (g > 0) begin
					ray_ch.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				ray_ch.ready <= 1'b1;
			end
		end
	end

	// result check on each accepted item
	always @(posedge clk) begin
		ray_t want;
		if (arst_n && ray_ch.valid && ray_ch.ready) begin
			if (pending_rays.size() == 0) begin
				$error("unexpected ray item");
				errors++;
			end else begin
				want = pending_rays.pop_front();
				if (ray_ch.dir_x !== want.dx) begin
					$error("dir_x expected %0d actual %0d", want.dx, ray_ch.dir_x);
					errors++;
				end
				if (ray_ch.dir_y !== want.dy) begin
					$error("dir_y expected %0d actual %0d", want.dy, ray_ch.dir_y);
					errors++;
				end
				if (ray_ch.dir_z !== want.dz) begin
					$error("dir_z expected %0d actual %0d", want.dz, ray_ch.dir_z);
					errors++;
				end
				if (ray_ch.density !== want.dens) begin
					$error("density expected %0d actual %0d", want.dens, ray_ch.density);
					errors++;
				end
			end
		end
	end

	// end of run and cycle limit
	initial begin
		fork
			begin
				wait (sending_done && pending_rays.size() == 0);
				repeat (tb_chs_pkg::LATENCY + 10) @(posedge clk);
			end
			begin
				while (cycles < CYCLE_CAP) begin
					@(posedge clk);
					cycles++;
				end
				$display("timeout");
				errors++;
			end
		join_any
		if (errors == 0 && pending_rays.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
